### hw/rtl/hci_pkg.sv
// shared types, constants and helper functions for the hsl color blender
package hci_pkg;

    // fixed point format of hue, lightness and saturation
    localparam int FRAC_BITS  = 16;
    localparam int ONE_W      = FRAC_BITS + 1;     // unsigned range 0..one
    localparam int DEN_W      = FRAC_BITS + 2;     // divisor range 0..two
    localparam int SW         = FRAC_BITS + 4;     // signed working width
    localparam int PW         = 2 * SW;            // signed product width
    localparam int PRW        = 2 * ONE_W + 1;     // unsigned product width

    // port widths
    localparam int COLOR_W    = 24;
    localparam int RATIO_W    = 17;
    localparam int RATIO_FRAC = 16;

    // queue between front and back
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    // pipeline depths
    localparam int DIV_STAGES = FRAC_BITS + 1;
    localparam int HSL_LAT    = DIV_STAGES + 4;
    localparam int MIX_LAT    = 2;
    localparam int RGB_LAT    = 5;
    localparam int BACK_LAT   = HSL_LAT + MIX_LAT + RGB_LAT + 1;

    // divide by six through a reciprocal, exact for values below 2^(FRAC_BITS+3)
    localparam int     K6     = FRAC_BITS + 6;
    localparam longint M6_L   = ((longint'(1) << K6) + 5) / 6;
    localparam int     M6_W   = K6 - 1;
    localparam int     HMAG_W = FRAC_BITS + 3;
    localparam int     H6P_W  = HMAG_W + M6_W;
    localparam logic [M6_W-1:0] M6 = M6_W'(M6_L);

    // fixed point constants
    localparam logic [ONE_W-1:0] U_ONE  = ONE_W'(longint'(1) << FRAC_BITS);
    localparam logic [ONE_W-1:0] U_HALF = ONE_W'(longint'(1) << (FRAC_BITS - 1));
    localparam logic [DEN_W-1:0] U_TWO  = DEN_W'(longint'(2) << FRAC_BITS);
    localparam logic signed [SW-1:0] S_ONE   = SW'(longint'(1) << FRAC_BITS);
    localparam logic signed [SW-1:0] S_TWO   = SW'(longint'(2) << FRAC_BITS);
    localparam logic signed [SW-1:0] S_FOUR  = SW'(longint'(4) << FRAC_BITS);
    localparam logic signed [SW-1:0] S_THIRD = SW'((longint'(1) << FRAC_BITS) / 3);
    localparam logic signed [SW-1:0] S_TWO_THIRDS = SW'((longint'(2) << FRAC_BITS) / 3);

    // byte to fixed point lookup: c * one / 255
    typedef logic [ONE_W-1:0] t_fix_tab [256];

    function automatic t_fix_tab build_fix_tab();
        t_fix_tab tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = ONE_W'((longint'(i) << FRAC_BITS) / 255);
        end
        return tab;
    endfunction

    localparam t_fix_tab FIX_TAB = build_fix_tab();

    // one queued transaction
    typedef struct packed {
        logic                      byp;
        logic [COLOR_W-1:0]        byp_color;
        logic [RATIO_FRAC-1:0]     ratio;
        logic [2:0][ONE_W-1:0]     fix_lo;
        logic [2:0][ONE_W-1:0]     fix_hi;
    } t_item;

    // signed shift right that truncates toward zero
    function automatic logic signed [PW-1:0] tdiv_pow2(input logic signed [PW-1:0] p,
                                                       input int sh);
        logic signed [PW-1:0] bias;
        bias = p[PW-1] ? $signed((PW'(1) << sh) - PW'(1)) : '0;
        return (p + bias) >>> sh;
    endfunction

endpackage

### hw/rtl/hsl_color_interpolation.sv
// top level of the hsl color blender: front end with queue and back end pipeline
//
// Blends two 0xRRGGBB colors in hue, lightness and saturation space by a Q1.16
// ratio; a ratio of zero returns the first color and one or more the second.
// One transaction is accepted per clock and one result leaves per clock while
// the queue is not full and the output is not stalled. A result passes
// through the queue and then the back end, most of which is the two
// saturation and hue dividers, which retire one quotient bit per pipeline
// stage. A four entry queue sits between the front and the back, so input
// is still taken while a finished result waits at the output, until the
// queue is full.
module hsl_color_interpolation (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [hci_pkg::COLOR_W-1:0]      i_color_low,
    input  logic [hci_pkg::COLOR_W-1:0]      i_color_high,
    input  logic [hci_pkg::RATIO_W-1:0]      i_blend_ratio,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [hci_pkg::COLOR_W-1:0]      o_color_out
);

    logic            q_valid;
    logic            q_pop;
    hci_pkg::t_item  q_item;

    // accept and classify
    hci_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_color_low   (i_color_low),
        .i_color_high  (i_color_high),
        .i_blend_ratio (i_blend_ratio),
        .i_q_pop       (q_pop),
        .o_q_valid     (q_valid),
        .o_q_item      (q_item)
    );

    // convert, blend and convert back
    hci_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_color_out (o_color_out)
    );

endmodule

### hw/rtl/hci_front.sv
// front end: accepts transactions, classifies them and queues them for the back end
module hci_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [hci_pkg::COLOR_W-1:0]      i_color_low,
    input  logic [hci_pkg::COLOR_W-1:0]      i_color_high,
    input  logic [hci_pkg::RATIO_W-1:0]      i_blend_ratio,
    input  logic                             i_q_pop,
    output logic                             o_q_valid,
    output hci_pkg::t_item                   o_q_item
);

    hci_pkg::t_item                 r_mem [hci_pkg::QDEPTH];
    logic [hci_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [hci_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [hci_pkg::QCNT_W-1:0]     r_count;
    logic [hci_pkg::QCNT_W-1:0]     n_count;
    hci_pkg::t_item                 n_item;
    logic                           push;

    // classify: ratio zero or one and above bypass the color math
    always_comb begin
        n_item.ratio = i_blend_ratio[hci_pkg::RATIO_FRAC-1:0];
        if (i_blend_ratio == '0) begin
            n_item.byp       = 1'b1;
            n_item.byp_color = i_color_low;
        end else if (i_blend_ratio[hci_pkg::RATIO_W-1]) begin
            n_item.byp       = 1'b1;
            n_item.byp_color = i_color_high;
        end else begin
            n_item.byp       = 1'b0;
            n_item.byp_color = i_color_low;
        end
        for (int c = 0; c < 3; c++) begin
            n_item.fix_lo[c] = hci_pkg::FIX_TAB[i_color_low[8*c +: 8]];
            n_item.fix_hi[c] = hci_pkg::FIX_TAB[i_color_high[8*c +: 8]];
        end
    end

    // queue control
    assign o_in_stall = (r_count == hci_pkg::QCNT_W'(hci_pkg::QDEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != '0);
    assign o_q_item   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (push && !i_q_pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_q_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= n_item;
        end
    end

    // back end never pops an empty queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> (r_count != '0))
        else $error("queue popped while empty");

    // fill level follows pushes and pops
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_q_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count lost a push");

endmodule

### hw/rtl/hci_div.sv
// pipelined restoring divider, one quotient bit per stage, computes a * one / d
module hci_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [hci_pkg::ONE_W-1:0]    i_dividend,
    input  logic [hci_pkg::DEN_W-1:0]    i_divisor,
    output logic [hci_pkg::ONE_W-1:0]    o_quotient
);

    localparam int N = hci_pkg::DIV_STAGES;

    logic [hci_pkg::DEN_W-1:0] r_rem [N];
    logic [hci_pkg::DEN_W-1:0] n_rem [N];
    logic [hci_pkg::DEN_W-1:0] r_den [N];
    logic [hci_pkg::DEN_W-1:0] n_den [N];
    logic [hci_pkg::ONE_W-1:0] r_quo [N];
    logic [hci_pkg::ONE_W-1:0] n_quo [N];

    // first stage decides the integer bit
    always_comb begin
        logic [hci_pkg::DEN_W:0] rem0;
        logic                    ge0;
        rem0     = (hci_pkg::DEN_W + 1)'(i_dividend);
        ge0      = rem0 >= {1'b0, i_divisor};
        n_rem[0] = ge0 ? hci_pkg::DEN_W'(rem0 - {1'b0, i_divisor})
                       : hci_pkg::DEN_W'(rem0);
        n_den[0] = i_divisor;
        n_quo[0] = hci_pkg::ONE_W'(ge0);
    end

    // remaining stages: shift, compare, subtract
    always_comb begin
        for (int k = 1; k < N; k++) begin
            logic [hci_pkg::DEN_W:0] rem_in;
            logic                    ge;
            rem_in   = {r_rem[k-1], 1'b0};
            ge       = rem_in >= {1'b0, r_den[k-1]};
            n_rem[k] = ge ? hci_pkg::DEN_W'(rem_in - {1'b0, r_den[k-1]})
                          : hci_pkg::DEN_W'(rem_in);
            n_den[k] = r_den[k-1];
            n_quo[k] = {r_quo[k-1][hci_pkg::ONE_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= n_den[k];
                r_quo[k] <= n_quo[k];
            end
        end
    end

    assign o_quotient = r_quo[N-1];

endmodule

### hw/rtl/hci_to_hsl.sv
// pipelined rgb to hue, lightness and saturation conversion
module hci_to_hsl (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [2:0][hci_pkg::ONE_W-1:0]     i_fix,
    output logic [hci_pkg::ONE_W-1:0]          o_hue,
    output logic [hci_pkg::ONE_W-1:0]          o_light,
    output logic [hci_pkg::ONE_W-1:0]          o_sat
);

    localparam int N = hci_pkg::DIV_STAGES;

    // first stage signals
    logic [hci_pkg::ONE_W-1:0]     mx, mn, d, l0, mag0;
    logic [hci_pkg::DEN_W-1:0]     sum0, sden0;
    logic signed [hci_pkg::SW-1:0] num0, base0;

    logic [hci_pkg::ONE_W-1:0]     r_d, r_mag, r_l;
    logic [hci_pkg::DEN_W-1:0]     r_sden;
    logic signed [hci_pkg::SW-1:0] r_base;
    logic                          r_neg, r_grey;

    // side data aligned with the dividers
    logic [hci_pkg::ONE_W-1:0]     r_l_d    [N];
    logic signed [hci_pkg::SW-1:0] r_base_d [N];
    logic                          r_neg_d  [N];
    logic                          r_grey_d [N];

    logic [hci_pkg::ONE_W-1:0]     s_quo, h_quo;

    // hue finishing stages
    logic signed [hci_pkg::SW-1:0] hsum;
    logic [hci_pkg::HMAG_W-1:0]    r_hmag;
    logic                          r_hneg1, r_hneg2;
    logic [hci_pkg::H6P_W-1:0]     r_hprod;
    logic [hci_pkg::ONE_W-1:0]     r_l1, r_l2, r_s1, r_s2, r_l3, r_s3, r_h3;
    logic                          r_grey1, r_grey2;
    logic [hci_pkg::ONE_W-1:0]     q6, hv;

    // extremes, lightness, divisor and hue sector
    always_comb begin
        mx = i_fix[2];
        mn = i_fix[2];
        if (i_fix[1] > mx) mx = i_fix[1];
        if (i_fix[0] > mx) mx = i_fix[0];
        if (i_fix[1] < mn) mn = i_fix[1];
        if (i_fix[0] < mn) mn = i_fix[0];
        sum0  = hci_pkg::DEN_W'(mx) + hci_pkg::DEN_W'(mn);
        l0    = hci_pkg::ONE_W'(sum0 >> 1);
        d     = mx - mn;
        sden0 = (l0 < hci_pkg::U_HALF) ? sum0 : hci_pkg::DEN_W'(hci_pkg::U_TWO - sum0);
        if (i_fix[2] == mx) begin
            num0  = hci_pkg::SW'(i_fix[1]) - hci_pkg::SW'(i_fix[0]);
            base0 = '0;
        end else if (i_fix[1] == mx) begin
            num0  = hci_pkg::SW'(i_fix[0]) - hci_pkg::SW'(i_fix[2]);
            base0 = hci_pkg::S_TWO;
        end else begin
            num0  = hci_pkg::SW'(i_fix[2]) - hci_pkg::SW'(i_fix[1]);
            base0 = hci_pkg::S_FOUR;
        end
        mag0 = num0[hci_pkg::SW-1] ? hci_pkg::ONE_W'(-num0) : hci_pkg::ONE_W'(num0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d    <= d;
            r_mag  <= mag0;
            r_l    <= l0;
            r_sden <= sden0;
            r_base <= base0;
            r_neg  <= num0[hci_pkg::SW-1];
            r_grey <= (mx == mn);
        end
    end

    // saturation and hue fraction dividers
    hci_div u_div_sat (
        .i_clk      (i_clk),
        .i_en       (i_en),
        .i_dividend (r_d),
        .i_divisor  (r_sden),
        .o_quotient (s_quo)
    );

    hci_div u_div_hue (
        .i_clk      (i_clk),
        .i_en       (i_en),
        .i_dividend (r_mag),
        .i_divisor  (hci_pkg::DEN_W'(r_d)),
        .o_quotient (h_quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l_d[0]    <= r_l;
            r_base_d[0] <= r_base;
            r_neg_d[0]  <= r_neg;
            r_grey_d[0] <= r_grey;
            for (int k = 1; k < N; k++) begin
                r_l_d[k]    <= r_l_d[k-1];
                r_base_d[k] <= r_base_d[k-1];
                r_neg_d[k]  <= r_neg_d[k-1];
                r_grey_d[k] <= r_grey_d[k-1];
            end
        end
    end

    // sector base plus signed fraction
    assign hsum = r_neg_d[N-1] ? r_base_d[N-1] - hci_pkg::SW'(h_quo)
                               : r_base_d[N-1] + hci_pkg::SW'(h_quo);

    // divide by six toward zero and wrap negatives
    assign q6 = hci_pkg::ONE_W'(r_hprod >> hci_pkg::K6);
    always_comb begin
        if (r_grey2) begin
            hv = '0;
        end else if (r_hneg2 && q6 != '0) begin
            hv = hci_pkg::U_ONE - q6;
        end else if (r_hneg2) begin
            hv = '0;
        end else begin
            hv = q6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hmag  <= hsum[hci_pkg::SW-1] ? hci_pkg::HMAG_W'(-hsum) : hci_pkg::HMAG_W'(hsum);
            r_hneg1 <= hsum[hci_pkg::SW-1];
            r_l1    <= r_l_d[N-1];
            r_s1    <= r_grey_d[N-1] ? '0 : s_quo;
            r_grey1 <= r_grey_d[N-1];

            r_hprod <= hci_pkg::H6P_W'(r_hmag) * hci_pkg::H6P_W'(hci_pkg::M6);
            r_hneg2 <= r_hneg1;
            r_l2    <= r_l1;
            r_s2    <= r_s1;
            r_grey2 <= r_grey1;

            r_h3    <= hv;
            r_l3    <= r_l2;
            r_s3    <= r_s2;
        end
    end

    assign o_hue   = r_h3;
    assign o_light = r_l3;
    assign o_sat   = r_s3;

endmodule

### hw/rtl/hci_from_hsl.sv
// pipelined hue, lightness and saturation to rgb conversion
module hci_from_hsl (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [hci_pkg::ONE_W-1:0]     i_hue,
    input  logic [hci_pkg::ONE_W-1:0]     i_light,
    input  logic [hci_pkg::ONE_W-1:0]     i_sat,
    output logic [hci_pkg::COLOR_W-1:0]   o_rgb
);

    typedef enum logic [1:0] {SEG_RISE, SEG_FLAT, SEG_FALL, SEG_LOW} t_seg;

    // stage one
    logic [hci_pkg::PRW-1:0]       r_prod0;
    logic [hci_pkg::ONE_W-1:0]     r_l0, r_s0, r_h0;
    logic                          r_lhalf0;

    // stage two
    logic signed [hci_pkg::SW-1:0] m2, m1, l_s, s_s;
    logic signed [hci_pkg::SW-1:0] hue_c [3];
    logic signed [hci_pkg::SW-1:0] fac_c [3];
    t_seg                          seg_c [3];
    logic signed [hci_pkg::SW-1:0] r_dm1, r_m11, r_m21, r_l1;
    logic signed [hci_pkg::SW-1:0] r_fac1 [3];
    t_seg                          r_seg1 [3];
    logic                          r_grey1;

    // stage three
    logic signed [hci_pkg::PW-1:0] r_prod2 [3];
    logic signed [hci_pkg::SW-1:0] r_m12, r_m22, r_l2;
    t_seg                          r_seg2 [3];
    logic                          r_grey2;

    // stage four and five
    logic signed [hci_pkg::SW-1:0] val_c [3];
    logic signed [hci_pkg::SW-1:0] r_val3 [3];
    logic [7:0]                    byte_c [3];
    logic [hci_pkg::COLOR_W-1:0]   r_rgb;

    // l * (one + s) or l * s
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lhalf0 <= (i_light <= hci_pkg::U_HALF);
            r_prod0  <= (i_light <= hci_pkg::U_HALF)
                ? hci_pkg::PRW'(i_light) * (hci_pkg::PRW'(hci_pkg::U_ONE) + hci_pkg::PRW'(i_sat))
                : hci_pkg::PRW'(i_light) * hci_pkg::PRW'(i_sat);
            r_l0     <= i_light;
            r_s0     <= i_sat;
            r_h0     <= i_hue;
        end
    end

    // m1, m2 and per channel hue segment
    always_comb begin
        logic signed [hci_pkg::SW-1:0] p_s;
        logic signed [hci_pkg::SW-1:0] h_s;
        logic signed [hci_pkg::SW-1:0] x;
        logic signed [hci_pkg::SW-1:0] six;
        p_s = hci_pkg::SW'(r_prod0 >> hci_pkg::FRAC_BITS);
        l_s = hci_pkg::SW'(r_l0);
        s_s = hci_pkg::SW'(r_s0);
        h_s = hci_pkg::SW'(r_h0);
        m2  = r_lhalf0 ? p_s : l_s + s_s - p_s;
        m1  = (l_s <<< 1) - m2;
        hue_c[0] = h_s - hci_pkg::S_THIRD;
        hue_c[1] = h_s;
        hue_c[2] = h_s + hci_pkg::S_THIRD;
        for (int c = 0; c < 3; c++) begin
            x = hue_c[c];
            if (x < 0) x = x + hci_pkg::S_ONE;
            if (x > hci_pkg::S_ONE) x = x - hci_pkg::S_ONE;
            six = (x <<< 2) + (x <<< 1);
            if (six < hci_pkg::S_ONE) begin
                seg_c[c] = SEG_RISE;
                fac_c[c] = six;
            end else if ((x <<< 1) < hci_pkg::S_ONE) begin
                seg_c[c] = SEG_FLAT;
                fac_c[c] = '0;
            end else if ((x <<< 1) + x < hci_pkg::S_TWO) begin
                seg_c[c] = SEG_FALL;
                fac_c[c] = ((hci_pkg::S_TWO_THIRDS - x) <<< 2)
                         + ((hci_pkg::S_TWO_THIRDS - x) <<< 1);
            end else begin
                seg_c[c] = SEG_LOW;
                fac_c[c] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dm1   <= m2 - m1;
            r_m11   <= m1;
            r_m21   <= m2;
            r_l1    <= l_s;
            r_grey1 <= (r_s0 == '0);
            for (int c = 0; c < 3; c++) begin
                r_fac1[c] <= fac_c[c];
                r_seg1[c] <= seg_c[c];
            end
        end
    end

    // (m2 - m1) times segment factor
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_prod2[c] <= hci_pkg::PW'(r_dm1) * hci_pkg::PW'(r_fac1[c]);
                r_seg2[c]  <= r_seg1[c];
            end
            r_m12   <= r_m11;
            r_m22   <= r_m21;
            r_l2    <= r_l1;
            r_grey2 <= r_grey1;
        end
    end

    // channel value per segment
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            case (r_seg2[c])
                SEG_RISE, SEG_FALL: val_c[c] = r_m12
                    + hci_pkg::SW'(hci_pkg::tdiv_pow2(r_prod2[c], hci_pkg::FRAC_BITS));
                SEG_FLAT: val_c[c] = r_m22;
                SEG_LOW:  val_c[c] = r_m12;
                default:  val_c[c] = r_m12;
            endcase
            if (r_grey2) val_c[c] = r_l2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_val3[c] <= val_c[c];
            end
        end
    end

    // scale to a byte and saturate
    always_comb begin
        logic signed [hci_pkg::SW+7:0] w;
        logic signed [hci_pkg::SW+7:0] q;
        for (int c = 0; c < 3; c++) begin
            w = ((hci_pkg::SW + 8)'(r_val3[c]) <<< 8) - (hci_pkg::SW + 8)'(r_val3[c]);
            q = w >>> hci_pkg::FRAC_BITS;
            if (r_val3[c] < 0) begin
                byte_c[c] = 8'd0;
            end else if (q > (hci_pkg::SW + 8)'(255)) begin
                byte_c[c] = 8'hFF;
            end else begin
                byte_c[c] = q[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rgb <= {byte_c[2], byte_c[1], byte_c[0]};
        end
    end

    assign o_rgb = r_rgb;

endmodule

### hw/rtl/hci_back.sv
// back end: hsl conversion of both colors, blend, conversion back, output register
module hci_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_valid,
    input  hci_pkg::t_item                   i_q_item,
    output logic                             o_q_pop,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [hci_pkg::COLOR_W-1:0]      o_color_out
);

    localparam int L    = hci_pkg::BACK_LAT;
    localparam int HL   = hci_pkg::HSL_LAT;

    logic                              advance;
    logic [L-1:0]                      r_vld;
    logic                              r_byp  [L-1];
    logic [hci_pkg::COLOR_W-1:0]       r_bcol [L-1];
    logic [hci_pkg::RATIO_FRAC-1:0]    r_ratio [HL];
    logic [hci_pkg::COLOR_W-1:0]       r_out;

    logic [hci_pkg::ONE_W-1:0]         hsl_lo [3];
    logic [hci_pkg::ONE_W-1:0]         hsl_hi [3];
    logic signed [hci_pkg::PW-1:0]     r_mprod [3];
    logic signed [hci_pkg::SW-1:0]     r_mx1   [3];
    logic [hci_pkg::ONE_W-1:0]         r_mix   [3];
    logic [hci_pkg::COLOR_W-1:0]       rgb;

    // whole pipeline moves unless a finished result is held
    assign advance     = !(r_vld[L-1] && i_out_stall);
    assign o_q_pop     = advance && i_q_valid;
    assign o_out_valid = r_vld[L-1];
    assign o_color_out = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (advance) begin
            r_vld <= {r_vld[L-2:0], i_q_valid};
        end
    end

    // bypass color and ratio travel beside the math
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_byp[0]   <= i_q_item.byp;
            r_bcol[0]  <= i_q_item.byp_color;
            for (int k = 1; k < L - 1; k++) begin
                r_byp[k]  <= r_byp[k-1];
                r_bcol[k] <= r_bcol[k-1];
            end
            r_ratio[0] <= i_q_item.ratio;
            for (int k = 1; k < HL; k++) begin
                r_ratio[k] <= r_ratio[k-1];
            end
        end
    end

    // both colors to hsl
    hci_to_hsl u_hsl_lo (
        .i_clk   (i_clk),
        .i_en    (advance),
        .i_fix   (i_q_item.fix_lo),
        .o_hue   (hsl_lo[0]),
        .o_light (hsl_lo[1]),
        .o_sat   (hsl_lo[2])
    );

    hci_to_hsl u_hsl_hi (
        .i_clk   (i_clk),
        .i_en    (advance),
        .i_fix   (i_q_item.fix_hi),
        .o_hue   (hsl_hi[0]),
        .o_light (hsl_hi[1]),
        .o_sat   (hsl_hi[2])
    );

    // linear blend of each component
    always_ff @(posedge i_clk) begin
        if (advance) begin
            for (int c = 0; c < 3; c++) begin
                r_mprod[c] <= hci_pkg::PW'($signed(hci_pkg::SW'(hsl_hi[c])
                                                 - hci_pkg::SW'(hsl_lo[c])))
                            * hci_pkg::PW'({1'b0, r_ratio[HL-1]});
                r_mx1[c]   <= hci_pkg::SW'(hsl_lo[c]);
                r_mix[c]   <= hci_pkg::ONE_W'(r_mx1[c]
                            + hci_pkg::SW'(hci_pkg::tdiv_pow2(r_mprod[c], hci_pkg::RATIO_FRAC)));
            end
        end
    end

    hci_from_hsl u_rgb (
        .i_clk   (i_clk),
        .i_en    (advance),
        .i_hue   (r_mix[0]),
        .i_light (r_mix[1]),
        .i_sat   (r_mix[2]),
        .o_rgb   (rgb)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= r_byp[L-2] ? r_bcol[L-2] : rgb;
        end
    end

    // a held result freezes every stage
    a_hold_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[L-1] && i_out_stall) |=> $stable(r_vld))
        else $error("pipeline moved while output held");

    // a popped transaction enters the first stage
    a_pop_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_vld[0])
        else $error("popped transaction lost");

endmodule

### tb/tb.sv
// testbench for the hsl color blender: queued driver, clocked monitor, fixed point predictor
`timescale 1ns / 1ps

module tb;

    localparam int RATIO_ONE = 65536;
    localparam longint FONE  = longint'(1) << hci_pkg::FRAC_BITS;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [hci_pkg::COLOR_W-1:0] lo;
        logic [hci_pkg::COLOR_W-1:0] hi;
        logic [hci_pkg::RATIO_W-1:0] ratio;
    } t_blend;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    logic [hci_pkg::COLOR_W-1:0]  i_color_low = '0;
    logic [hci_pkg::COLOR_W-1:0]  i_color_high = '0;
    logic [hci_pkg::RATIO_W-1:0]  i_blend_ratio = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic [hci_pkg::COLOR_W-1:0]  o_color_out;

    t_blend                      pending_q[$];
    logic [hci_pkg::COLOR_W-1:0] color_exp_q[$];
    int  send_idle_pct = 10;
    int  recv_idle_pct = 50;
    int  error_count = 0;
    int  cycle_count = 0;
    bit  stim_done = 1'b0;

    hsl_color_interpolation dut (.*);

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // truncating signed division
    function automatic longint tdiv(longint a, longint b);
        longint q;
        q = (a < 0 ? -a : a) / (b < 0 ? -b : b);
        return ((a < 0) != (b < 0)) ? -q : q;
    endfunction

    // one channel of the hsl to rgb conversion
    function automatic longint hue_channel(longint m1, longint m2, longint h);
        if (h < 0) h += FONE;
        if (h > FONE) h -= FONE;
        if (6 * h < FONE) return m1 + tdiv((m2 - m1) * 6 * h, FONE);
        if (2 * h < FONE) return m2;
        if (3 * h < 2 * FONE) return m1 + tdiv((m2 - m1) * 6 * ((2 * FONE) / 3 - h), FONE);
        return m1;
    endfunction

    function automatic logic [7:0] fix_to_byte(longint v);
        longint c;
        if (v < 0) return 8'd0;
        c = tdiv(v * 255, FONE);
        return (c > 255) ? 8'd255 : 8'(c);
    endfunction

    // rgb to hue, lightness, saturation
    function automatic void split_hsl(input logic [hci_pkg::COLOR_W-1:0] rgb,
                                      output longint h, output longint l,
                                      output longint s);
        longint r, g, b, mx, mn, d, num, base;
        r = (longint'(rgb[23:16]) << hci_pkg::FRAC_BITS) / 255;
        g = (longint'(rgb[15:8]) << hci_pkg::FRAC_BITS) / 255;
        b = (longint'(rgb[7:0]) << hci_pkg::FRAC_BITS) / 255;
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        l = (mx + mn) / 2;
        if (mx == mn) begin
            s = 0;
            h = 0;
        end else begin
            d = mx - mn;
            if (l < FONE / 2) s = (d * FONE) / (mx + mn);
            else s = (d * FONE) / (2 * FONE - mx - mn);
            if (r == mx) begin
                num = g - b; base = 0;
            end else if (g == mx) begin
                num = b - r; base = 2 * FONE;
            end else begin
                num = r - g; base = 4 * FONE;
            end
            h = tdiv(base + tdiv(num * FONE, d), 6);
            if (h < 0) h += FONE;
        end
    endfunction

    function automatic logic [hci_pkg::COLOR_W-1:0] blend_color(t_blend it);
        longint h1, l1, s1, h2, l2, s2, h, l, s, m1, m2, t;
        t = it.ratio;
        if (t == 0) return it.lo;
        if (t >= RATIO_ONE) return it.hi;
        split_hsl(it.lo, h1, l1, s1);
        split_hsl(it.hi, h2, l2, s2);
        h = h1 + tdiv((h2 - h1) * t, RATIO_ONE);
        l = l1 + tdiv((l2 - l1) * t, RATIO_ONE);
        s = s1 + tdiv((s2 - s1) * t, RATIO_ONE);
        if (s == 0) return {fix_to_byte(l), fix_to_byte(l), fix_to_byte(l)};
        if (l <= FONE / 2) m2 = (l * (FONE + s)) / FONE;
        else m2 = l + s - (l * s) / FONE;
        m1 = 2 * l - m2;
        return {fix_to_byte(hue_channel(m1, m2, h + FONE / 3)),
                fix_to_byte(hue_channel(m1, m2, h)),
                fix_to_byte(hue_channel(m1, m2, h - FONE / 3))};
    endfunction

    function automatic logic [hci_pkg::COLOR_W-1:0] rand_color();
        case ($urandom_range(0, 5))
            0: return {3{8'($urandom)}};
            1: return {8'(255 * $urandom_range(0, 1)), 8'(255 * $urandom_range(0, 1)),
                       8'(255 * $urandom_range(0, 1))};
            default: return hci_pkg::COLOR_W'($urandom);
        endcase
    endfunction

    function automatic logic [hci_pkg::RATIO_W-1:0] rand_ratio();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return hci_pkg::RATIO_W'(RATIO_ONE);
            2: return hci_pkg::RATIO_W'($urandom_range(RATIO_ONE + 1, 131071));
            3: return hci_pkg::RATIO_W'($urandom_range(1, 3));
            4: return hci_pkg::RATIO_W'($urandom_range(RATIO_ONE - 3, RATIO_ONE - 1));
            default: return hci_pkg::RATIO_W'($urandom_range(1, RATIO_ONE - 1));
        endcase
    endfunction

    task automatic add_item(logic [hci_pkg::COLOR_W-1:0] lo, logic [hci_pkg::COLOR_W-1:0] hi,
                            logic [hci_pkg::RATIO_W-1:0] r);
        t_blend it;
        it.lo = lo; it.hi = hi; it.ratio = r;
        pending_q.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || i_in_valid || color_exp_q.size() != 0)
            @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: ratio extremes, greys, primaries, hue wrap
        add_item(24'h123456, 24'hABCDEF, 17'd0);
        add_item(24'h123456, 24'hABCDEF, 17'd65536);
        add_item(24'h123456, 24'hABCDEF, 17'h1FFFF);
        add_item(24'h000000, 24'hFFFFFF, 17'd32768);
        add_item(24'hFFFFFF, 24'h000000, 17'd1);
        add_item(24'h808080, 24'h404040, 17'd65535);
        add_item(24'hFF0000, 24'h00FF00, 17'd32768);
        add_item(24'h00FF00, 24'h0000FF, 17'd32768);
        add_item(24'h0000FF, 24'hFF0000, 17'd32768);
        add_item(24'hFF00FF, 24'hFF0000, 17'd49152);
        add_item(24'hFF0080, 24'hFF8000, 17'd32768);
        add_item(24'h800000, 24'hFFC0C0, 17'd16384);
        add_item(24'hFF0000, 24'h808080, 17'd32768);
        add_item(24'h102030, 24'hFFFF00, 17'd65535);
        add_item(24'hFFFFFF, 24'hFFFFFF, 17'd12345);
        add_item(24'h000001, 24'hFEFFFF, 17'd40000);
        wait_drained();
        // random phases with changing idle mix
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 50 : 0;
            recv_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 10 : 0;
            repeat (630) add_item(rand_color(), rand_color(), rand_ratio());
            wait_drained();
        end
        repeat (hci_pkg::BACK_LAT + 10) @(posedge i_clk);
        stim_done = 1'b1;
    end

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n && !(i_in_valid && o_in_stall)) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                t_blend it;
                it = pending_q.pop_front();
                i_color_low   <= it.lo;
                i_color_high  <= it.hi;
                i_blend_ratio <= it.ratio;
                i_in_valid    <= 1'b1;
                color_exp_q.push_back(blend_color(it));
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // monitor
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (color_exp_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, o_color_out);
                error_count <= error_count + 1;
            end else begin
                logic [hci_pkg::COLOR_W-1:0] want;
                want = color_exp_q.pop_front();
                if (o_color_out !== want) begin
                    $display("%0t: color_out mismatch, expected %h, actual %h",
                             $time, want, o_color_out);
                    error_count <= error_count + 1;
                end
            end
        end
    end

    // end of run
    always @(posedge i_clk) begin
        if (stim_done) begin
            if (error_count == 0 && color_exp_q.size() == 0)
                $display("Verification passed");
            else
                $display("Verification failed");
            $finish;
        end else if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end
endmodule
